// ===== rtl/core/indexed_list_store_top_defines.svh =====
`ifndef INDEXED_LIST_STORE_TOP_DEFINES_SVH
`define INDEXED_LIST_STORE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside of reset.
`define ILS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside of reset.
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ils_pkg.sv =====
package ils_pkg;

  localparam int KIND_W = 3;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 16;
  localparam int DOUT_W = 16;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_SET    = 3'd2,
    KIND_GET    = 3'd3,
    KIND_REMOVE = 3'd4,
    KIND_CLEAR  = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET_RD,
    S_SET_WR,
    S_RM_FIRST,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_INS_LAST,
    S_RESP
  } state_t;

endpackage

// ===== rtl/core/list_req_if.sv =====
interface list_req_if;
  import ils_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  index;
  logic [VAL_W-1:0]  value;

  modport source (output valid, output kind, output index, output value, input ready);
  modport sink   (input valid, input kind, input index, input value, output ready);
endinterface

// ===== rtl/core/list_rsp_if.sv =====
interface list_rsp_if;
  import ils_pkg::*;

  logic              valid;
  logic              ready;
  logic [DOUT_W-1:0] data_out;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  count;

  modport source (output valid, output data_out, output status, output count, input ready);
  modport sink   (input valid, input data_out, input status, input count, output ready);
endinterface

// ===== rtl/core/ils_ram.sv =====
module ils_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/indexed_list_store_top.sv =====
// Bounded ordered list of data words held in one single-port-write RAM.
// in_chan carries one request (kind, index, value); every request gives
// exactly one result on out_chan (data_out, status, count). A transfer
// happens on a rising edge with valid and ready both high.
// One request is worked on at a time. Append, clear, insert at the end of the
// list and refused requests go straight to the result state; get and set
// first read the entry (S_GET_RD, S_SET_WR). Insert at a position i below the
// count n moves the tail up (S_SHIFT_UP, then S_INS_LAST), remove moves the
// entries above i down (S_RM_FIRST, S_SHIFT_DN): the RAM moves one entry per
// cycle (one read, one write). in_chan.ready rises at the edge that hands the
// result to the output register, so a new request follows only that handoff.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is accepted and worked on, and only the handoff of
// that next result waits until the register is free.
// Synchronous reset empties the list and drops any pending result; the RAM
// contents are not cleared, since only entries below the count are read.
module indexed_list_store_top #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  list_req_if.sink   in_chan,
  list_rsp_if.source out_chan
);
  import ils_pkg::*;

  `include "indexed_list_store_top_defines.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > IDX_W) ? CW : IDX_W) + 1;
  localparam int VW = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  status_t               status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DOUT_W-1:0]     out_data_r, out_data_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [CNT_W-1:0]      out_count_r, out_count_nxt;

  logic                  accept;
  logic                  full;
  logic [DATA_WIDTH-1:0] in_word;
  logic [XW-1:0]         idx_x, cnt_x, ptr_x, idx_rx;
  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;

  assign in_chan.ready     = (state_r == S_IDLE);
  assign accept            = in_chan.valid && in_chan.ready;
  assign full              = (count_r == CW'(CAPACITY));
  assign in_word           = DATA_WIDTH'(in_chan.value[VW-1:0]);
  assign idx_x             = XW'(in_chan.index);
  assign cnt_x             = XW'(count_r);
  assign ptr_x             = XW'(ptr_r);
  assign idx_rx            = XW'(idx_r);

  assign out_chan.valid    = out_valid_r;
  assign out_chan.data_out = out_data_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.count    = out_count_r;

  ils_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    idx_r        <= idx_nxt;
    word_r       <= word_nxt;
    data_r       <= data_nxt;
    status_r     <= status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    idx_nxt        = idx_r;
    word_nxt       = word_r;
    data_nxt       = data_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    rd_en          = 1'b0;
    rd_addr        = ptr_r;
    wr_en          = 1'b0;
    wr_addr        = ptr_r;
    wr_data        = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt    = AW'(in_chan.index);
          word_nxt   = in_word;
          data_nxt   = '0;
          status_nxt = STAT_OK;
          state_nxt  = S_RESP;
          unique case (kind_t'(in_chan.kind))
            KIND_APPEND: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = AW'(count_r);
                wr_data   = in_word;
                count_nxt = count_r + CW'(1);
              end
            end
            KIND_INSERT: begin
              if (idx_x > cnt_x) begin
                status_nxt = STAT_RANGE;
              end else if (full) begin
                status_nxt = STAT_FULL;
              end else if (idx_x == cnt_x) begin
                wr_en     = 1'b1;
                wr_addr   = AW'(count_r);
                wr_data   = in_word;
                count_nxt = count_r + CW'(1);
              end else begin
                // Move the tail up starting from the last entry.
                rd_en     = 1'b1;
                rd_addr   = AW'(count_r - CW'(1));
                ptr_nxt   = AW'(count_r);
                state_nxt = S_SHIFT_UP;
              end
            end
            KIND_SET, KIND_GET, KIND_REMOVE: begin
              if (idx_x >= cnt_x) begin
                status_nxt = STAT_RANGE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = AW'(in_chan.index);
                ptr_nxt = AW'(in_chan.index);
                if (kind_t'(in_chan.kind) == KIND_SET) begin
                  state_nxt = S_SET_WR;
                end else if (kind_t'(in_chan.kind) == KIND_GET) begin
                  state_nxt = S_GET_RD;
                end else begin
                  state_nxt = S_RM_FIRST;
                end
              end
            end
            KIND_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_GET_RD: begin
        data_nxt  = rd_data;
        state_nxt = S_RESP;
      end
      S_SET_WR: begin
        data_nxt  = rd_data;
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = word_r;
        state_nxt = S_RESP;
      end
      S_RM_FIRST: begin
        data_nxt = rd_data;
        if (idx_rx + XW'(1) < cnt_x) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(idx_rx + XW'(1));
          state_nxt = S_SHIFT_DN;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end
      end
      S_SHIFT_DN: begin
        // rd_data holds the entry above ptr_r; the read two ahead runs alongside.
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data;
        if (ptr_x + XW'(2) < cnt_x) begin
          rd_en   = 1'b1;
          rd_addr = AW'(ptr_x + XW'(2));
          ptr_nxt = AW'(ptr_x + XW'(1));
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end
      end
      S_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data;
        if (ptr_x - XW'(1) > idx_rx) begin
          rd_en   = 1'b1;
          rd_addr = AW'(ptr_x - XW'(2));
          ptr_nxt = AW'(ptr_x - XW'(1));
        end else begin
          state_nxt = S_INS_LAST;
        end
      end
      S_INS_LAST: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = word_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = DOUT_W'(data_r[VW-1:0]);
          out_status_nxt = status_r;
          out_count_nxt  = CNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `ILS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(CAPACITY),
    "entry count above capacity")
  `ILS_ASSERT_NOW(a_dn_spacing, (state_r == S_SHIFT_DN) && rd_en,
    XW'(rd_addr) == XW'(wr_addr) + XW'(2), "shift-down read not two ahead of write")
  `ILS_ASSERT_NOW(a_up_spacing, (state_r == S_SHIFT_UP) && rd_en,
    XW'(rd_addr) + XW'(2) == XW'(wr_addr), "shift-up read not two below write")
  `ILS_ASSERT_NEXT(a_resp_count, state_r == S_RESP, $stable(count_r),
    "entry count changed while handing off a result")
  `ILS_ASSERT_NEXT(a_resp_load, (state_r == S_RESP) && (!out_valid_r || out_chan.ready),
    out_valid_r && (out_count_r == CNT_W'(count_r)), "result not loaded into output register")

endmodule
